// File: rtl/bmfc_pkg.sv
// Shared types and constants of the box mesh face connectivity block.
`timescale 1ns / 1ps

package bmfc_pkg;

  localparam int unsigned IDX_W      = 30;
  localparam int unsigned PT_W       = 31;
  localparam int unsigned AXIS_W     = 11;
  localparam int unsigned CRD_W      = 10;
  localparam int unsigned REM_W      = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned MAX_CELLS  = 1024;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = IDX_W / DIV_STEPS;

  localparam logic REQ_CELL = 1'b0;
  localparam logic REQ_EXT  = 1'b1;

  localparam logic [2:0] SIDE_XM = 3'd0;
  localparam logic [2:0] SIDE_XP = 3'd1;
  localparam logic [2:0] SIDE_YM = 3'd2;
  localparam logic [2:0] SIDE_YP = 3'd3;
  localparam logic [2:0] SIDE_ZM = 3'd4;
  localparam logic [2:0] SIDE_ZP = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELLS_X,
    CFG_CELLS_Y,
    CFG_CELLS_Z
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_e;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] item_index;
  } in_word_t;

  typedef struct packed {
    logic [PT_W-1:0]  corner_a;
    logic [PT_W-1:0]  corner_b;
    logic [PT_W-1:0]  corner_c;
    logic [PT_W-1:0]  corner_d;
    logic [IDX_W-1:0] owner_cell;
    logic [IDX_W-1:0] neighbour_cell;
    logic [2:0]       face_side;
    logic             no_face;
    logic             bad_index;
    logic             last_result;
  } out_word_t;

  typedef struct packed {
    logic             ext;
    logic             bad;
    axis_e            region;
    logic             plus;
    logic [IDX_W-1:0] idx;
    logic [REM_W-1:0] r1;
  } pipe_t;

endpackage

// File: rtl/bmfc_div.sv
// Pipelined restoring divider, two quotient bits per stage, with sideband.
`timescale 1ns / 1ps

module bmfc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [bmfc_pkg::IDX_W-1:0]    dividend_i,
  input  logic [bmfc_pkg::AXIS_W-1:0]   divisor_i,
  input  bmfc_pkg::pipe_t               side_i,
  output logic                          valid_o,
  output logic [bmfc_pkg::IDX_W-1:0]    quot_o,
  output logic [bmfc_pkg::REM_W-1:0]    rem_o,
  output bmfc_pkg::pipe_t               side_o
);

  localparam int unsigned N = bmfc_pkg::DIV_STAGES;

  logic [N-1:0]                    valid_q;
  logic [N-1:0]                    valid_d;
  logic [bmfc_pkg::REM_W-1:0]      rem_q [N];
  logic [bmfc_pkg::REM_W-1:0]      rem_d [N];
  logic [bmfc_pkg::IDX_W-1:0]      dq_q  [N];
  logic [bmfc_pkg::IDX_W-1:0]      dq_d  [N];
  logic [bmfc_pkg::AXIS_W-1:0]     dvs_q [N];
  logic [bmfc_pkg::AXIS_W-1:0]     dvs_d [N];
  bmfc_pkg::pipe_t                 side_q[N];
  bmfc_pkg::pipe_t                 side_d[N];

  always_comb begin
    logic [bmfc_pkg::REM_W:0]   trial;
    logic [bmfc_pkg::REM_W-1:0] r;
    logic [bmfc_pkg::IDX_W-1:0] q;
    for (int s = 0; s < N; s++) begin
      if (s == 0) begin
        r          = '0;
        q          = dividend_i;
        dvs_d[s]   = divisor_i;
        side_d[s]  = side_i;
        valid_d[s] = valid_i;
      end else begin
        r          = rem_q[s-1];
        q          = dq_q[s-1];
        dvs_d[s]   = dvs_q[s-1];
        side_d[s]  = side_q[s-1];
        valid_d[s] = valid_q[s-1];
      end
      for (int k = 0; k < bmfc_pkg::DIV_STEPS; k++) begin
        trial = {r, q[bmfc_pkg::IDX_W-1]};
        if (trial >= dvs_d[s]) begin
          r = bmfc_pkg::REM_W'(trial - dvs_d[s]);
          q = {q[bmfc_pkg::IDX_W-2:0], 1'b1};
        end else begin
          r = trial[bmfc_pkg::REM_W-1:0];
          q = {q[bmfc_pkg::IDX_W-2:0], 1'b0};
        end
      end
      rem_d[s] = r;
      dq_d[s]  = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < N; s++) begin
        rem_q[s]  <= rem_d[s];
        dq_q[s]   <= dq_d[s];
        dvs_q[s]  <= dvs_d[s];
        side_q[s] <= side_d[s];
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign quot_o  = dq_q[N-1];
  assign rem_o   = rem_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

// File: rtl/box_mesh_face_connectivity.sv
// Top level of the box mesh face connectivity block.
// Takes one request word per cycle unless in_stall_o is high and gives face words: a cell
// request gives one to three words (its +x, +y, +z internal faces, or one empty or error word),
// an external-face request one word. The output port gives one word per cycle while out_stall_i
// is low, so a cell request with several faces holds the input until its last word is out. Two
// 15-stage dividers split the index into coordinates. After reset and after each register write
// the input stalls while the derived sizes settle.
`timescale 1ns / 1ps

module box_mesh_face_connectivity (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bmfc_pkg::in_word_t               in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output bmfc_pkg::out_word_t              out_word_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bmfc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bmfc_pkg::AXIS_W-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W  = bmfc_pkg::IDX_W;
  localparam int unsigned PT_W   = bmfc_pkg::PT_W;
  localparam int unsigned AXIS_W = bmfc_pkg::AXIS_W;
  localparam int unsigned CRD_W  = bmfc_pkg::CRD_W;
  localparam int unsigned SQ_W   = 21;
  localparam int unsigned CNT_W  = 31;
  localparam int unsigned FC_W   = 23;
  localparam int unsigned K_W    = 22;
  localparam logic [1:0]  SETTLE = 2'd2;

  typedef struct packed {
    logic             ext;
    logic             bad;
    logic [2:0]       side;
    logic [2:0]       mask;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] nei0;
    logic [IDX_W-1:0] nei1;
    logic [IDX_W-1:0] nei2;
    logic [CRD_W-1:0] x;
  } meta_t;

  typedef struct packed {
    logic             multi;
    logic             bad;
    logic             noface;
    logic [2:0]       side;
    logic [2:0]       mask;
    logic [PT_W-1:0]  p0;
    logic [IDX_W-1:0] own;
    logic [IDX_W-1:0] nei0;
    logic [IDX_W-1:0] nei1;
    logic [IDX_W-1:0] nei2;
  } rec_t;

  function automatic logic [AXIS_W-1:0] axis_clamp(input logic [AXIS_W-1:0] v);
    if (v == '0) begin
      return AXIS_W'(1);
    end else if (v > AXIS_W'(bmfc_pkg::MAX_CELLS)) begin
      return AXIS_W'(bmfc_pkg::MAX_CELLS);
    end
    return v;
  endfunction

  // configuration and derived sizes
  logic [AXIS_W-1:0] nx_q, ny_q, nz_q;
  logic [1:0]        settle_q;
  logic [SQ_W-1:0]   sxy_q, syz_q, sxz_q, pxy_q;
  logic [AXIS_W-1:0] px_q;
  logic [CNT_W-1:0]  cellcnt_q;
  logic [FC_W-1:0]   b1_q, b2_q, facecnt_q;
  logic [K_W-1:0]    pxp1_q, pxy1_q, pxypx_q, pxypx1_q;
  logic              cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q     <= AXIS_W'(1);
      ny_q     <= AXIS_W'(1);
      nz_q     <= AXIS_W'(1);
      settle_q <= SETTLE;
    end else begin
      if (cfg_wr) begin
        settle_q <= SETTLE;
        unique case (bmfc_pkg::cfg_reg_e'(cfg_index_i))
          bmfc_pkg::CFG_CELLS_X: nx_q <= axis_clamp(cfg_data_i);
          bmfc_pkg::CFG_CELLS_Y: ny_q <= axis_clamp(cfg_data_i);
          bmfc_pkg::CFG_CELLS_Z: nz_q <= axis_clamp(cfg_data_i);
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sxy_q     <= SQ_W'(SQ_W'(nx_q) * SQ_W'(ny_q));
    syz_q     <= SQ_W'(SQ_W'(ny_q) * SQ_W'(nz_q));
    sxz_q     <= SQ_W'(SQ_W'(nx_q) * SQ_W'(nz_q));
    px_q      <= nx_q + AXIS_W'(1);
    pxy_q     <= SQ_W'((SQ_W'(nx_q) + SQ_W'(1)) * (SQ_W'(ny_q) + SQ_W'(1)));
    cellcnt_q <= CNT_W'(CNT_W'(sxy_q) * CNT_W'(nz_q));
    b1_q      <= FC_W'({syz_q, 1'b0});
    b2_q      <= FC_W'({FC_W'(syz_q) + FC_W'(sxz_q), 1'b0});
    facecnt_q <= FC_W'({FC_W'(syz_q) + FC_W'(sxz_q) + FC_W'(sxy_q), 1'b0});
    pxp1_q    <= K_W'(px_q) + K_W'(1);
    pxy1_q    <= K_W'(pxy_q) + K_W'(1);
    pxypx_q   <= K_W'(pxy_q) + K_W'(px_q);
    pxypx1_q  <= K_W'(pxy_q) + K_W'(px_q) + K_W'(1);
  end

  // pipeline advance
  logic adv;
  logic f_valid_q;
  logic rec_take;

  assign adv        = !f_valid_q || rec_take;
  assign in_stall_o = !adv || (settle_q != '0);

  // stage A: input word
  logic               a_valid_q;
  bmfc_pkg::in_word_t a_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_valid_i && (settle_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_word_q <= in_word_i;
    end
  end

  // stage B: range check and side block
  logic             b_valid_q;
  bmfc_pkg::pipe_t  b_side_q, b_side_d;
  logic [IDX_W-1:0] b_t0_q, b_t0_d;

  always_comb begin
    logic [IDX_W-1:0] idx;
    idx             = a_word_q.item_index;
    b_side_d        = '0;
    b_side_d.ext    = (a_word_q.req_type == bmfc_pkg::REQ_EXT);
    b_side_d.idx    = idx;
    if (b_side_d.ext) begin
      b_side_d.bad = idx >= IDX_W'(facecnt_q);
    end else begin
      b_side_d.bad = {1'b0, idx} >= cellcnt_q;
    end
    if (idx < IDX_W'(b1_q)) begin
      b_side_d.region = bmfc_pkg::AX_X;
      b_t0_d          = idx;
    end else if (idx < IDX_W'(b2_q)) begin
      b_side_d.region = bmfc_pkg::AX_Y;
      b_t0_d          = idx - IDX_W'(b1_q);
    end else begin
      b_side_d.region = bmfc_pkg::AX_Z;
      b_t0_d          = idx - IDX_W'(b2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_side_q <= b_side_d;
      b_t0_q   <= b_t0_d;
    end
  end

  // stage C: minus or plus side, divider operands
  logic              c_valid_q;
  bmfc_pkg::pipe_t   c_side_q, c_side_d;
  logic [IDX_W-1:0]  c_dvd_q, c_dvd_d;
  logic [AXIS_W-1:0] c_dvs_q, c_dvs_d;

  always_comb begin
    logic [SQ_W-1:0]  size;
    logic [IDX_W-1:0] t;
    case (b_side_q.region)
      bmfc_pkg::AX_X: size = syz_q;
      bmfc_pkg::AX_Y: size = sxz_q;
      default:        size = sxy_q;
    endcase
    c_side_d      = b_side_q;
    c_side_d.plus = b_t0_q >= IDX_W'(size);
    t             = c_side_d.plus ? (b_t0_q - IDX_W'(size)) : b_t0_q;
    if (b_side_q.ext) begin
      c_dvd_d = t;
      c_dvs_d = (b_side_q.region == bmfc_pkg::AX_Y) ? nz_q : ny_q;
    end else begin
      c_dvd_d = b_side_q.idx;
      c_dvs_d = nx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_side_q <= c_side_d;
      c_dvd_q  <= c_dvd_d;
      c_dvs_q  <= c_dvs_d;
    end
  end

  // two dividers
  logic                        v1, v2;
  logic [IDX_W-1:0]            q1, q2;
  logic [bmfc_pkg::REM_W-1:0]  r1, r2;
  bmfc_pkg::pipe_t             s1, s1_fwd, s2;
  logic [AXIS_W-1:0]           dvs2;

  bmfc_div u_div_lo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (c_valid_q),
    .dividend_i (c_dvd_q),
    .divisor_i  (c_dvs_q),
    .side_i     (c_side_q),
    .valid_o    (v1),
    .quot_o     (q1),
    .rem_o      (r1),
    .side_o     (s1)
  );

  always_comb begin
    s1_fwd    = s1;
    s1_fwd.r1 = r1;
    dvs2      = s1.ext ? AXIS_W'(1) : ny_q;
  end

  bmfc_div u_div_hi (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (v1),
    .dividend_i (q1),
    .divisor_i  (dvs2),
    .side_i     (s1_fwd),
    .valid_o    (v2),
    .quot_o     (q2),
    .rem_o      (r2),
    .side_o     (s2)
  );

  // stage D: owner coordinates, faces present, neighbours
  logic             d_valid_q;
  meta_t            d_meta_q, d_meta_d;
  logic [CRD_W-1:0] d_y_q, d_z_q, d_x, d_y, d_z;

  always_comb begin
    logic [CRD_W-1:0] a;
    logic [CRD_W-1:0] b;
    logic [CRD_W-1:0] nxm1, nym1, nzm1;
    a    = q2[CRD_W-1:0];
    b    = s2.r1;
    nxm1 = CRD_W'(nx_q - AXIS_W'(1));
    nym1 = CRD_W'(ny_q - AXIS_W'(1));
    nzm1 = CRD_W'(nz_q - AXIS_W'(1));
    if (!s2.ext) begin
      d_x = s2.r1;
      d_y = r2;
      d_z = a;
    end else begin
      case (s2.region)
        bmfc_pkg::AX_X: begin
          d_x = s2.plus ? nxm1 : '0;
          d_y = b;
          d_z = a;
        end
        bmfc_pkg::AX_Y: begin
          d_x = a;
          d_y = s2.plus ? nym1 : '0;
          d_z = b;
        end
        default: begin
          d_x = a;
          d_y = b;
          d_z = s2.plus ? nzm1 : '0;
        end
      endcase
    end
    d_meta_d      = '0;
    d_meta_d.ext  = s2.ext;
    d_meta_d.bad  = s2.bad;
    d_meta_d.side = {s2.region, s2.plus};
    d_meta_d.idx  = s2.idx;
    d_meta_d.x    = d_x;
    d_meta_d.nei0 = s2.idx + IDX_W'(1);
    d_meta_d.nei1 = s2.idx + IDX_W'(nx_q);
    d_meta_d.nei2 = s2.idx + IDX_W'(sxy_q);
    if (!s2.ext) begin
      d_meta_d.mask = {(AXIS_W'(d_z) + AXIS_W'(1)) < nz_q,
                       (AXIS_W'(d_y) + AXIS_W'(1)) < ny_q,
                       (AXIS_W'(d_x) + AXIS_W'(1)) < nx_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (adv) begin
      d_valid_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_meta_q <= d_meta_d;
      d_y_q    <= d_y;
      d_z_q    <= d_z;
    end
  end

  // stage E: products
  logic            e_valid_q;
  meta_t           e_meta_q;
  logic [PT_W-1:0] e_zp_q;
  logic [SQ_W-1:0] e_yp_q, e_ys_q;
  logic [IDX_W-1:0] e_zs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (adv) begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_meta_q <= d_meta_q;
      e_zp_q   <= PT_W'(PT_W'(d_z_q) * PT_W'(pxy_q));
      e_yp_q   <= SQ_W'(SQ_W'(d_y_q) * SQ_W'(px_q));
      e_zs_q   <= IDX_W'(IDX_W'(d_z_q) * IDX_W'(sxy_q));
      e_ys_q   <= SQ_W'(SQ_W'(d_y_q) * SQ_W'(nx_q));
    end
  end

  // stage F: base point and owner
  meta_t            f_meta_q;
  logic [PT_W-1:0]  f_p0_q;
  logic [IDX_W-1:0] f_own_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (adv) begin
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_meta_q <= e_meta_q;
      f_p0_q   <= e_zp_q + PT_W'(e_yp_q) + PT_W'(e_meta_q.x);
      f_own_q  <= e_zs_q + IDX_W'(e_ys_q) + IDX_W'(e_meta_q.x);
    end
  end

  // record of one request and face serialiser
  logic                rec_valid_q;
  rec_t                rec_q, rec_d;
  logic                out_valid_q;
  bmfc_pkg::out_word_t out_word_q, out_word_d;
  logic                out_free, emit, last;
  logic [2:0]          rest;

  always_comb begin
    rec_d        = '0;
    rec_d.bad    = f_meta_q.bad;
    rec_d.noface = !f_meta_q.bad && !f_meta_q.ext && (f_meta_q.mask == '0);
    rec_d.multi  = !f_meta_q.bad && !f_meta_q.ext && (f_meta_q.mask != '0);
    rec_d.side   = f_meta_q.side;
    rec_d.mask   = f_meta_q.mask;
    rec_d.p0     = f_p0_q;
    rec_d.own    = f_own_q;
    rec_d.nei0   = f_meta_q.nei0;
    rec_d.nei1   = f_meta_q.nei1;
    rec_d.nei2   = f_meta_q.nei2;
  end

  always_comb begin
    logic [2:0]       pick;
    logic [2:0]       side;
    logic [IDX_W-1:0] nei;
    logic [K_W-1:0]   ka, kb, kc, kd;
    if (rec_q.mask[0]) begin
      pick = 3'b001;
      side = bmfc_pkg::SIDE_XP;
      nei  = rec_q.nei0;
    end else if (rec_q.mask[1]) begin
      pick = 3'b010;
      side = bmfc_pkg::SIDE_YP;
      nei  = rec_q.nei1;
    end else begin
      pick = 3'b100;
      side = bmfc_pkg::SIDE_ZP;
      nei  = rec_q.nei2;
    end
    rest = rec_q.mask & ~pick;
    if (!rec_q.multi) begin
      side = rec_q.side;
      nei  = '0;
    end
    last = !rec_q.multi || (rest == '0);
    unique case (side)
      bmfc_pkg::SIDE_XM: begin
        ka = '0;             kb = K_W'(pxy_q); kc = pxypx_q;  kd = K_W'(px_q);
      end
      bmfc_pkg::SIDE_XP: begin
        ka = K_W'(1);        kb = pxp1_q;      kc = pxypx1_q; kd = pxy1_q;
      end
      bmfc_pkg::SIDE_YM: begin
        ka = '0;             kb = K_W'(1);     kc = pxy1_q;   kd = K_W'(pxy_q);
      end
      bmfc_pkg::SIDE_YP: begin
        ka = K_W'(px_q);     kb = pxypx_q;     kc = pxypx1_q; kd = pxp1_q;
      end
      bmfc_pkg::SIDE_ZM: begin
        ka = '0;             kb = K_W'(px_q);  kc = pxp1_q;   kd = K_W'(1);
      end
      bmfc_pkg::SIDE_ZP: begin
        ka = K_W'(pxy_q);    kb = pxy1_q;      kc = pxypx1_q; kd = pxypx_q;
      end
      default: begin
        ka = '0;             kb = '0;          kc = '0;       kd = '0;
      end
    endcase
    out_word_d             = '0;
    out_word_d.last_result = last;
    if (rec_q.bad) begin
      out_word_d.bad_index = 1'b1;
    end else if (rec_q.noface) begin
      out_word_d.no_face    = 1'b1;
      out_word_d.owner_cell = rec_q.own;
    end else begin
      out_word_d.corner_a       = rec_q.p0 + PT_W'(ka);
      out_word_d.corner_b       = rec_q.p0 + PT_W'(kb);
      out_word_d.corner_c       = rec_q.p0 + PT_W'(kc);
      out_word_d.corner_d       = rec_q.p0 + PT_W'(kd);
      out_word_d.owner_cell     = rec_q.own;
      out_word_d.neighbour_cell = nei;
      out_word_d.face_side      = side;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = rec_valid_q && out_free;
  assign rec_take = !rec_valid_q || (emit && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rec_take) begin
        rec_valid_q <= f_valid_q;
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_take) begin
      rec_q <= rec_d;
    end else if (emit) begin
      rec_q.mask <= rest;
    end
    if (emit) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_cfg_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o)
    else $error("input taken right after a register write");

  a_bad_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.bad_index |-> out_word_o.last_result && !out_word_o.no_face)
    else $error("error word not final");

  a_mid_side : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last_result |->
      (out_word_o.face_side == bmfc_pkg::SIDE_XP || out_word_o.face_side == bmfc_pkg::SIDE_YP))
    else $error("non-final word on wrong side");

  a_rec_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid_q && rec_q.multi |-> rec_q.mask != '0)
    else $error("face record with no face pending");

endmodule

// File: tb/bmfc_face_checker.sv
// Checker for the box mesh face connectivity block: predicts face words and compares them.
`timescale 1ns / 1ps

module bmfc_face_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  bmfc_pkg::in_word_t             in_word_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  bmfc_pkg::out_word_t            out_word_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bmfc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bmfc_pkg::AXIS_W-1:0]    cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             words_checked_o
);

  logic [bmfc_pkg::AXIS_W-1:0] size_x, size_y, size_z;
  bmfc_pkg::out_word_t         face_q[$];

  assign pending_o = face_q.size();

  function automatic longint unsigned axis_eff(logic [bmfc_pkg::AXIS_W-1:0] v);
    if (v == 0) return 1;
    if (v > bmfc_pkg::MAX_CELLS) return bmfc_pkg::MAX_CELLS;
    return v;
  endfunction

  function automatic bmfc_pkg::out_word_t make_face(longint unsigned a, longint unsigned b,
                                                    longint unsigned c, longint unsigned d,
                                                    longint unsigned own,
                                                    longint unsigned nei,
                                                    logic [2:0] side);
    bmfc_pkg::out_word_t r;
    r = '0;
    r.corner_a       = a[bmfc_pkg::PT_W-1:0];
    r.corner_b       = b[bmfc_pkg::PT_W-1:0];
    r.corner_c       = c[bmfc_pkg::PT_W-1:0];
    r.corner_d       = d[bmfc_pkg::PT_W-1:0];
    r.owner_cell     = own[bmfc_pkg::IDX_W-1:0];
    r.neighbour_cell = nei[bmfc_pkg::IDX_W-1:0];
    r.face_side      = side;
    return r;
  endfunction

  function automatic void predict_faces(bmfc_pkg::in_word_t w);
    longint unsigned nx, ny, nz, px, pxy, idx, lim, x, y, z, p, t, a, b, syz, sxz, sxy;
    logic                plus;
    bmfc_pkg::out_word_t r;
    bmfc_pkg::out_word_t words[$];
    nx  = axis_eff(size_x);
    ny  = axis_eff(size_y);
    nz  = axis_eff(size_z);
    px  = nx + 1;
    pxy = (nx + 1) * (ny + 1);
    syz = ny * nz;
    sxz = nx * nz;
    sxy = nx * ny;
    idx = w.item_index;
    lim = (w.req_type == bmfc_pkg::REQ_CELL) ? nx * ny * nz : 2 * (sxy + sxz + syz);
    if (idx >= lim) begin
      r = '0;
      r.bad_index = 1'b1;
      words = {words, r};
    end else if (w.req_type == bmfc_pkg::REQ_CELL) begin
      x = idx % nx;
      y = (idx / nx) % ny;
      z = idx / sxy;
      if (x + 1 < nx) begin
        p = z * pxy + y * px + x + 1;
        words = {words, make_face(p, p + px, p + px + pxy, p + pxy, idx, idx + 1,
                                  bmfc_pkg::SIDE_XP)};
      end
      if (y + 1 < ny) begin
        p = z * pxy + (y + 1) * px + x;
        words = {words, make_face(p, p + pxy, p + pxy + 1, p + 1, idx, idx + nx,
                                  bmfc_pkg::SIDE_YP)};
      end
      if (z + 1 < nz) begin
        p = (z + 1) * pxy + y * px + x;
        words = {words, make_face(p, p + 1, p + 1 + px, p + px, idx, idx + sxy,
                                  bmfc_pkg::SIDE_ZP)};
      end
      if (words.size() == 0) begin
        r = '0;
        r.owner_cell = idx[bmfc_pkg::IDX_W-1:0];
        r.no_face    = 1'b1;
        words = {words, r};
      end
    end else if (idx < 2 * syz) begin
      plus = idx >= syz;
      t = plus ? idx - syz : idx;
      a = t / ny;
      b = t % ny;
      if (!plus) begin
        p = a * pxy + b * px;
        words = {words, make_face(p, p + pxy, p + pxy + px, p + px, b * nx + a * sxy, 0,
                                  bmfc_pkg::SIDE_XM)};
      end else begin
        p = a * pxy + b * px + nx;
        words = {words, make_face(p, p + px, p + px + pxy, p + pxy,
                                  b * nx + a * sxy + nx - 1, 0, bmfc_pkg::SIDE_XP)};
      end
    end else if (idx < 2 * syz + 2 * sxz) begin
      t = idx - 2 * syz;
      plus = t >= sxz;
      if (plus) t = t - sxz;
      a = t / nz;
      b = t % nz;
      if (!plus) begin
        p = b * pxy + a;
        words = {words, make_face(p, p + 1, p + 1 + pxy, p + pxy, a + b * sxy, 0,
                                  bmfc_pkg::SIDE_YM)};
      end else begin
        p = b * pxy + a + px * ny;
        words = {words, make_face(p, p + pxy, p + pxy + 1, p + 1,
                                  a + b * sxy + nx * (ny - 1), 0, bmfc_pkg::SIDE_YP)};
      end
    end else begin
      t = idx - 2 * syz - 2 * sxz;
      plus = t >= sxy;
      if (plus) t = t - sxy;
      a = t / ny;
      b = t % ny;
      if (!plus) begin
        p = b * px + a;
        words = {words, make_face(p, p + px, p + px + 1, p + 1, a + b * nx, 0,
                                  bmfc_pkg::SIDE_ZM)};
      end else begin
        p = b * px + a + pxy * nz;
        words = {words, make_face(p, p + 1, p + 1 + px, p + px,
                                  a + b * nx + sxy * (nz - 1), 0, bmfc_pkg::SIDE_ZP)};
      end
    end
    words[words.size() - 1].last_result = 1'b1;
    foreach (words[i]) face_q = {face_q, words[i]};
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x          = 1;
      size_y          = 1;
      size_z          = 1;
      fail_count_o    = 0;
      words_checked_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bmfc_pkg::CFG_CELLS_X: size_x = cfg_data_i;
          bmfc_pkg::CFG_CELLS_Y: size_y = cfg_data_i;
          bmfc_pkg::CFG_CELLS_Z: size_z = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_faces(in_word_i);
      if (out_valid_i && !out_stall_i) begin
        bmfc_pkg::out_word_t e;
        if (face_q.size() == 0) begin
          $error("unexpected face word %h", out_word_i);
          fail_count_o++;
        end else begin
          e = face_q.pop_front();
          words_checked_o++;
          check_field("corner_a", e.corner_a, out_word_i.corner_a);
          check_field("corner_b", e.corner_b, out_word_i.corner_b);
          check_field("corner_c", e.corner_c, out_word_i.corner_c);
          check_field("corner_d", e.corner_d, out_word_i.corner_d);
          check_field("owner_cell", e.owner_cell, out_word_i.owner_cell);
          check_field("neighbour_cell", e.neighbour_cell, out_word_i.neighbour_cell);
          check_field("face_side", e.face_side, out_word_i.face_side);
          check_field("no_face", e.no_face, out_word_i.no_face);
          check_field("bad_index", e.bad_index, out_word_i.bad_index);
          check_field("last_result", e.last_result, out_word_i.last_result);
        end
      end
    end
  end

endmodule

// File: tb/tb_box_mesh_face_connectivity.sv
// Testbench top for the box mesh face connectivity block: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_box_mesh_face_connectivity;

  localparam logic [bmfc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int                             SETTLE    = 60;
  localparam int                             RAND_PER  = 48;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  bmfc_pkg::in_word_t             in_word_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  bmfc_pkg::out_word_t            out_word_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [bmfc_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [bmfc_pkg::AXIS_W-1:0]    cfg_data_i = '0;

  int  fail_count, pending, words_checked;
  int  stall_left = 0;
  int  items_sent = 0;
  int  shapes = 0;
  bit  no_gaps = 1'b0;
  bit  took = 1'b0;
  longint unsigned nx = 1, ny = 1, nz = 1;

  always #5 clk_i = ~clk_i;

  box_mesh_face_connectivity uut (.*);

  bmfc_face_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_word_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .words_checked_o(words_checked)
  );

  always @(posedge clk_i) begin
    took <= out_valid_o && !out_stall_i;
  end

  always @(negedge clk_i) begin
    if (took) stall_left = no_gaps ? 0 : $urandom_range(0, 3);
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic longint unsigned eff(int unsigned v);
    if (v == 0) return 1;
    if (v > bmfc_pkg::MAX_CELLS) return bmfc_pkg::MAX_CELLS;
    return v;
  endfunction

  task automatic write_reg(logic [bmfc_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val[bmfc_pkg::AXIS_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_box(int unsigned sx, int unsigned sy, int unsigned sz);
    drain();
    repeat (SETTLE) @(negedge clk_i);
    write_reg(bmfc_pkg::CFG_CELLS_X, sx);
    write_reg(bmfc_pkg::CFG_CELLS_Y, sy);
    write_reg(bmfc_pkg::CFG_CELLS_Z, sz);
    nx = eff(sx);
    ny = eff(sy);
    nz = eff(sz);
    shapes++;
  endtask

  task automatic send(logic kind, longint unsigned idx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i.req_type   = kind;
    in_word_i.item_index = idx[bmfc_pkg::IDX_W-1:0];
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_random();
    logic            kind;
    longint unsigned lim, idx, top;
    int              pick;
    kind = $urandom_range(0, 1);
    lim  = (kind == bmfc_pkg::REQ_CELL) ? nx * ny * nz : 2 * (nx * ny + nx * nz + ny * nz);
    top  = 64'd1 << bmfc_pkg::IDX_W;
    pick = $urandom_range(0, 99);
    if (pick < 85 || lim >= top) idx = $urandom_range(0, lim - 1);
    else if (pick < 93) idx = lim + ($urandom % (top - lim));
    else idx = $urandom & (top - 1);
    send(kind, idx);
  endtask

  initial begin
    int unsigned shape_x[8] = '{1, 1024, 0, 2, 1, 7, 1024, 5};
    int unsigned shape_y[8] = '{1, 1024, 2047, 1, 1, 3, 1, 9};
    int unsigned shape_z[8] = '{1, 1024, 6, 1, 9, 2, 3, 4};
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    write_reg(CFG_SPARE, 5);
    set_box(3, 4, 5);
    send(bmfc_pkg::REQ_CELL, 0);
    send(bmfc_pkg::REQ_CELL, 2);
    send(bmfc_pkg::REQ_CELL, 11);
    send(bmfc_pkg::REQ_CELL, 59);
    send(bmfc_pkg::REQ_CELL, 60);
    send(bmfc_pkg::REQ_CELL, 30'h3FFF_FFFF);
    send(bmfc_pkg::REQ_EXT, 0);
    send(bmfc_pkg::REQ_EXT, 19);
    send(bmfc_pkg::REQ_EXT, 20);
    send(bmfc_pkg::REQ_EXT, 39);
    send(bmfc_pkg::REQ_EXT, 40);
    send(bmfc_pkg::REQ_EXT, 54);
    send(bmfc_pkg::REQ_EXT, 55);
    send(bmfc_pkg::REQ_EXT, 69);
    send(bmfc_pkg::REQ_EXT, 70);
    send(bmfc_pkg::REQ_EXT, 81);
    send(bmfc_pkg::REQ_EXT, 82);
    send(bmfc_pkg::REQ_EXT, 93);
    send(bmfc_pkg::REQ_EXT, 94);
    send(bmfc_pkg::REQ_EXT, 30'h3FFF_FFFF);
    in_valid_i = 1'b0;
    for (int s = 0; s < 8; s++) begin
      set_box(shape_x[s], shape_y[s], shape_z[s]);
      no_gaps = (s == 2 || s == 5);
      for (int n = 0; n < RAND_PER; n++) begin
        if (s == 3 && n == 20) begin
          in_valid_i = 1'b0;
          drain();
        end
        send_random();
      end
      in_valid_i = 1'b0;
    end
    no_gaps = 1'b0;
    for (int n = 0; n < 30; n++) send_random();
    in_valid_i = 1'b0;
    drain();
    repeat (SETTLE) @(negedge clk_i);
    $display("Covered %0d requests over %0d box shapes, %0d face words checked.",
             items_sent, shapes, words_checked);
    $display("Shapes included single-cell and 1024-cell axes and clamped register values.");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
